### rtl/core/vpcp_pkg.sv
// Shared types and constants for the vector picture command parser.
// Used by the front, the job queue, the back and the checker. No dependencies.
package vpcp_pkg;

  // Record kinds as they appear on the result port.
  typedef enum logic [3:0] {
    K_MOVETO = 4'd0,
    K_LINETO = 4'd1,
    K_STROKE = 4'd2,
    K_CLOSE  = 4'd3,
    K_FONT   = 4'd4,
    K_TBEGIN = 4'd5,
    K_TCHAR  = 4'd6,
    K_TEND   = 4'd7,
    K_PAGE   = 4'd8,
    K_ERROR  = 4'd9
  } kind_t;

  // One flag per record a single byte may cause, in emission order.
  typedef struct packed {
    logic err;
    logic tend;
    logic stroke;
    logic font;
    logic move;
    logic tbegin;
    logic tchar;
    logic lineto;
    logic close;
    logic page;
  } job_flags_t;

  // Work handed from the front to the back for one input byte.
  typedef struct packed {
    job_flags_t  flags;
    logic [15:0] move_x;
    logic [15:0] move_y;
    logic [15:0] font_w;
    logic [15:0] font_h;
    logic [15:0] line_x;
    logic [15:0] line_y;
    logic [1:0]  rot;
    logic [2:0]  align;
    logic [7:0]  chr;
    logic        esc;
  } job_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

### rtl/core/vpcp_front.sv
// Front end of the parser: accepts bytes, tracks header, opcodes and operands,
// and turns each byte with records into one back end job. Depends on vpcp_pkg.
module vpcp_front #(
  parameter int HEADER_BYTES = 17,
  parameter int TEXT_LIMIT   = 254
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_file,
  input  logic             start_of_file,
  output logic             job_valid,
  output vpcp_pkg::job_t   job
);

  typedef enum logic [10:0] {
    PH_HEADER      = 11'b000_0000_0001,
    PH_OPCODE      = 11'b000_0000_0010,
    PH_MOVE        = 11'b000_0000_0100,
    PH_DRAW        = 11'b000_0000_1000,
    PH_POLY_COUNT  = 11'b000_0001_0000,
    PH_POLY_START  = 11'b000_0010_0000,
    PH_POLY_VERTEX = 11'b000_0100_0000,
    PH_FONT        = 11'b000_1000_0000,
    PH_SKIP        = 11'b001_0000_0000,
    PH_ALIGN       = 11'b010_0000_0000,
    PH_TEXT        = 11'b100_0000_0000
  } phase_t;

  localparam logic [7:0] OP_MOVE   = 8'hA0;
  localparam logic [7:0] OP_DRAW   = 8'hA2;
  localparam logic [7:0] OP_POLY_A = 8'h30;
  localparam logic [7:0] OP_POLY_B = 8'hD0;
  localparam logic [7:0] OP_FONT   = 8'hAC;
  localparam logic [7:0] OP_SELECT = 8'hA7;
  localparam logic [7:0] OP_TEXT   = 8'hA8;
  localparam logic [3:0] GRP_COLOR = 4'hB;
  localparam logic [3:0] GRP_END   = 4'h6;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [4:0] HEADER_INIT = 5'(HEADER_BYTES);
  localparam logic [7:0] TEXT_MAX    = 8'(TEXT_LIMIT);
  localparam phase_t     PHASE_INIT  = (HEADER_INIT == 5'd0) ? PH_OPCODE : PH_HEADER;

  logic [4:0]  header_left, header_left_next;
  phase_t      phase, phase_next;
  logic [1:0]  operand_index, operand_index_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [15:0] start_x, start_x_next;
  logic [15:0] start_y, start_y_next;
  logic [15:0] point_x, point_x_next;
  logic [15:0] font_width, font_width_next;
  logic [15:0] font_height, font_height_next;
  logic [7:0]  vertices_left, vertices_left_next;
  logic [7:0]  text_length, text_length_next;
  logic [1:0]  held_rotation, held_rotation_next;
  logic [2:0]  held_align, held_align_next;
  logic        stroke_open, stroke_open_next;
  logic        move_waiting, move_waiting_next;
  logic        font_waiting, font_waiting_next;
  logic        finished, finished_next;

  logic        esc;
  assign esc = (data_byte == CH_LPAREN) || (data_byte == CH_RPAREN) ||
               (data_byte == CH_BSLASH);

  always_comb begin
    logic        finish_req;
    logic [15:0] w;
    finish_req          = 1'b0;
    job                 = '0;
    header_left_next    = header_left;
    phase_next          = phase;
    operand_index_next  = operand_index;
    high_byte_hold_next = high_byte_hold;
    start_x_next        = start_x;
    start_y_next        = start_y;
    point_x_next        = point_x;
    font_width_next     = font_width;
    font_height_next    = font_height;
    vertices_left_next  = vertices_left;
    text_length_next    = text_length;
    held_rotation_next  = held_rotation;
    held_align_next     = held_align;
    stroke_open_next    = stroke_open;
    move_waiting_next   = move_waiting;
    font_waiting_next   = font_waiting;
    finished_next       = finished;

    if (start_of_file) begin
      header_left_next    = HEADER_INIT;
      phase_next          = PHASE_INIT;
      operand_index_next  = 2'd0;
      high_byte_hold_next = 8'd0;
      start_x_next        = 16'd0;
      start_y_next        = 16'd0;
      point_x_next        = 16'd0;
      font_width_next     = 16'd0;
      font_height_next    = 16'd0;
      vertices_left_next  = 8'd0;
      text_length_next    = 8'd0;
      held_rotation_next  = 2'd0;
      held_align_next     = 3'd0;
      stroke_open_next    = 1'b0;
      move_waiting_next   = 1'b0;
      font_waiting_next   = 1'b0;
      finished_next       = 1'b0;
    end

    w = {high_byte_hold_next, data_byte};

    if (!finished_next) begin
      if (end_of_file) begin
        if (phase_next == PH_TEXT && text_length_next != 8'd0) begin
          job.flags.tend = 1'b1;
        end
        text_length_next = 8'd0;
        finish_req = 1'b1;
      end else begin
        case (phase_next)
          PH_HEADER: begin
            if (header_left_next != 5'd0) begin
              header_left_next = header_left_next - 5'd1;
            end
            if (header_left_next == 5'd0) begin
              phase_next = PH_OPCODE;
            end
          end
          PH_OPCODE: begin
            operand_index_next = 2'd0;
            if (data_byte[7:4] == GRP_COLOR) begin
              // Color changes carry no drawing effect.
            end else if (data_byte == OP_MOVE) begin
              phase_next = PH_MOVE;
            end else if (data_byte == OP_DRAW) begin
              phase_next = PH_DRAW;
            end else if (data_byte == OP_POLY_A || data_byte == OP_POLY_B) begin
              phase_next = PH_POLY_COUNT;
            end else if (data_byte == OP_FONT) begin
              phase_next = PH_FONT;
            end else if (data_byte == OP_SELECT) begin
              phase_next = PH_SKIP;
            end else if (data_byte == OP_TEXT) begin
              phase_next = PH_ALIGN;
            end else if (data_byte[7:4] == GRP_END) begin
              finish_req = 1'b1;
            end else begin
              job.flags.err = 1'b1;
              finish_req = 1'b1;
            end
          end
          PH_SKIP: begin
            phase_next = PH_OPCODE;
          end
          PH_ALIGN: begin
            held_rotation_next = data_byte[5:4];
            held_align_next    = data_byte[2:0];
            text_length_next   = 8'd0;
            phase_next         = PH_TEXT;
          end
          PH_TEXT: begin
            if (data_byte == 8'd0) begin
              if (text_length_next != 8'd0) begin
                job.flags.tend = 1'b1;
              end
              text_length_next = 8'd0;
              phase_next = PH_OPCODE;
            end else if (text_length_next < TEXT_MAX) begin
              // The first kept character announces the string.
              if (text_length_next == 8'd0) begin
                job.flags.stroke  = stroke_open_next;
                stroke_open_next  = 1'b0;
                job.flags.font    = font_waiting_next;
                font_waiting_next = 1'b0;
                job.flags.move    = move_waiting_next;
                move_waiting_next = 1'b0;
                job.flags.tbegin  = 1'b1;
              end
              job.flags.tchar  = 1'b1;
              text_length_next = text_length_next + 8'd1 + {7'd0, esc};
            end
          end
          PH_POLY_COUNT: begin
            vertices_left_next = data_byte;
            operand_index_next = 2'd0;
            phase_next         = PH_POLY_START;
          end
          PH_MOVE, PH_DRAW, PH_POLY_START, PH_POLY_VERTEX, PH_FONT: begin
            if (!operand_index_next[0]) begin
              high_byte_hold_next = data_byte;
              operand_index_next  = operand_index_next + 2'd1;
            end else if (operand_index_next == 2'd1) begin
              if (phase_next == PH_MOVE || phase_next == PH_POLY_START) begin
                start_x_next = w;
              end else if (phase_next == PH_FONT) begin
                font_width_next = w;
              end else begin
                point_x_next = w;
              end
              operand_index_next = 2'd2;
            end else begin
              operand_index_next = 2'd0;
              if (phase_next == PH_MOVE) begin
                start_y_next      = w;
                job.flags.stroke  = stroke_open_next;
                stroke_open_next  = 1'b0;
                move_waiting_next = 1'b1;
                phase_next        = PH_OPCODE;
              end else if (phase_next == PH_DRAW) begin
                job.flags.move    = move_waiting_next;
                move_waiting_next = 1'b0;
                job.flags.lineto  = 1'b1;
                stroke_open_next  = 1'b1;
                phase_next        = PH_OPCODE;
              end else if (phase_next == PH_FONT) begin
                font_height_next  = w;
                font_waiting_next = 1'b1;
                phase_next        = PH_OPCODE;
              end else if (phase_next == PH_POLY_START) begin
                start_y_next   = w;
                job.flags.move = 1'b1;
                phase_next     = PH_POLY_VERTEX;
              end else begin
                job.flags.lineto = 1'b1;
                if (vertices_left_next != 8'd0) begin
                  vertices_left_next = vertices_left_next - 8'd1;
                end
              end
              if (phase_next == PH_POLY_VERTEX && vertices_left_next == 8'd0) begin
                job.flags.close = 1'b1;
                phase_next      = PH_OPCODE;
              end
            end
          end
          default: begin
            phase_next = PH_OPCODE;
          end
        endcase
      end
    end

    if (finish_req) begin
      job.flags.stroke = stroke_open_next;
      stroke_open_next = 1'b0;
      job.flags.page   = 1'b1;
      finished_next    = 1'b1;
    end

    job.move_x = start_x_next;
    job.move_y = start_y_next;
    job.font_w = font_width_next;
    job.font_h = font_height_next;
    job.line_x = point_x_next;
    job.line_y = w;
    job.rot    = held_rotation_next;
    job.align  = held_align_next;
    job.chr    = data_byte;
    job.esc    = esc;
  end

  assign job_valid = accept && (job.flags != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_left    <= HEADER_INIT;
      phase          <= PHASE_INIT;
      operand_index  <= 2'd0;
      high_byte_hold <= 8'd0;
      start_x        <= 16'd0;
      start_y        <= 16'd0;
      point_x        <= 16'd0;
      font_width     <= 16'd0;
      font_height    <= 16'd0;
      vertices_left  <= 8'd0;
      text_length    <= 8'd0;
      held_rotation  <= 2'd0;
      held_align     <= 3'd0;
      stroke_open    <= 1'b0;
      move_waiting   <= 1'b0;
      font_waiting   <= 1'b0;
      finished       <= 1'b0;
    end else if (accept) begin
      header_left    <= header_left_next;
      phase          <= phase_next;
      operand_index  <= operand_index_next;
      high_byte_hold <= high_byte_hold_next;
      start_x        <= start_x_next;
      start_y        <= start_y_next;
      point_x        <= point_x_next;
      font_width     <= font_width_next;
      font_height    <= font_height_next;
      vertices_left  <= vertices_left_next;
      text_length    <= text_length_next;
      held_rotation  <= held_rotation_next;
      held_align     <= held_align_next;
      stroke_open    <= stroke_open_next;
      move_waiting   <= move_waiting_next;
      font_waiting   <= font_waiting_next;
      finished       <= finished_next;
    end
  end

endmodule

### rtl/core/vpcp_job_queue.sv
// Short job queue between the parser front and the record back end.
// Depends on vpcp_pkg for the job type and depth.
module vpcp_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  vpcp_pkg::job_t wdata,
  input  logic           rd,
  output vpcp_pkg::job_t rdata,
  output logic           full,
  output logic           not_empty
);

  vpcp_pkg::job_t                 entries [vpcp_pkg::QUEUE_DEPTH];
  logic [vpcp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [vpcp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [vpcp_pkg::QPTR_W:0]      count;

  assign full      = (count == (vpcp_pkg::QPTR_W+1)'(vpcp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (vpcp_pkg::QPTR_W+1)'(wr) - (vpcp_pkg::QPTR_W+1)'(rd);
    end
  end

endmodule

### rtl/core/vpcp_back.sv
// Back end: expands each job into its records in the output register,
// one per cycle unless held. Depends on vpcp_pkg for job, record types.
module vpcp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  vpcp_pkg::job_t    q_data,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic [3:0]        record_kind,
  output logic [15:0]       coord_x,
  output logic [15:0]       coord_y,
  output logic [1:0]        text_rotation,
  output logic [2:0]        text_align,
  output logic [7:0]        char_code,
  output logic              needs_escape,
  output logic              last_of_run
);

  vpcp_pkg::job_t       cur;
  logic                 cur_valid;
  logic                 out_valid;
  vpcp_pkg::kind_t      out_kind;

  vpcp_pkg::job_flags_t rem;
  vpcp_pkg::kind_t      sel_kind;
  logic [15:0]          sel_x, sel_y;
  logic [1:0]           sel_rot;
  logic [2:0]           sel_align;
  logic [7:0]           sel_chr;
  logic                 sel_esc;
  logic                 emit;
  logic                 rem_zero;

  // Pick the earliest pending record of the current job.
  always_comb begin
    rem       = cur.flags;
    sel_kind  = vpcp_pkg::K_PAGE;
    sel_x     = 16'd0;
    sel_y     = 16'd0;
    sel_rot   = 2'd0;
    sel_align = 3'd0;
    sel_chr   = 8'd0;
    sel_esc   = 1'b0;
    if (cur.flags.err) begin
      sel_kind = vpcp_pkg::K_ERROR;
      sel_chr  = cur.chr;
      rem.err  = 1'b0;
    end else if (cur.flags.tend) begin
      sel_kind = vpcp_pkg::K_TEND;
      rem.tend = 1'b0;
    end else if (cur.flags.stroke) begin
      sel_kind   = vpcp_pkg::K_STROKE;
      rem.stroke = 1'b0;
    end else if (cur.flags.font) begin
      sel_kind = vpcp_pkg::K_FONT;
      sel_x    = cur.font_w;
      sel_y    = cur.font_h;
      rem.font = 1'b0;
    end else if (cur.flags.move) begin
      sel_kind = vpcp_pkg::K_MOVETO;
      sel_x    = cur.move_x;
      sel_y    = cur.move_y;
      rem.move = 1'b0;
    end else if (cur.flags.tbegin) begin
      sel_kind   = vpcp_pkg::K_TBEGIN;
      sel_rot    = cur.rot;
      sel_align  = cur.align;
      rem.tbegin = 1'b0;
    end else if (cur.flags.tchar) begin
      sel_kind  = vpcp_pkg::K_TCHAR;
      sel_chr   = cur.chr;
      sel_esc   = cur.esc;
      rem.tchar = 1'b0;
    end else if (cur.flags.lineto) begin
      sel_kind   = vpcp_pkg::K_LINETO;
      sel_x      = cur.line_x;
      sel_y      = cur.line_y;
      rem.lineto = 1'b0;
    end else if (cur.flags.close) begin
      sel_kind  = vpcp_pkg::K_CLOSE;
      rem.close = 1'b0;
    end else begin
      sel_kind = vpcp_pkg::K_PAGE;
      rem.page = 1'b0;
    end
  end

  assign rem_zero = (rem == '0);
  assign emit     = cur_valid && (!out_valid || pop);
  assign q_rd     = q_not_empty && (!cur_valid || (emit && rem_zero));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
    end else if (emit && rem_zero) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end else if (emit) begin
      cur.flags <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind      <= sel_kind;
      coord_x       <= sel_x;
      coord_y       <= sel_y;
      text_rotation <= sel_rot;
      text_align    <= sel_align;
      char_code     <= sel_chr;
      needs_escape  <= sel_esc;
      last_of_run   <= rem_zero;
    end
  end

  assign empty       = !out_valid;
  assign record_kind = out_kind;

endmodule

### rtl/core/vector_picture_command_parser.sv
// Vector picture command parser, top level. One byte is accepted per cycle
// while the four-entry job queue has room; records leave at one per cycle
// while popped. A byte's first record passes the job queue, the back end's
// current-job register and the output register to reach the result ports;
// the back end's expansion sets sustained throughput for multi-record bytes.
// Reset (synchronous, active high) empties the queue and output register.
module vector_picture_command_parser #(
  parameter int HEADER_BYTES = 17,
  parameter int TEXT_LIMIT   = 254
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  input  logic        start_of_file,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  record_kind,
  output logic [15:0] coord_x,
  output logic [15:0] coord_y,
  output logic [1:0]  text_rotation,
  output logic [2:0]  text_align,
  output logic [7:0]  char_code,
  output logic        needs_escape,
  output logic        last_of_run
);

  logic           accept;
  logic           job_valid;
  vpcp_pkg::job_t job;
  logic           q_rd;
  logic           q_not_empty;
  vpcp_pkg::job_t q_data;

  assign accept = push && !full;

  vpcp_front #(
    .HEADER_BYTES(HEADER_BYTES),
    .TEXT_LIMIT  (TEXT_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .end_of_file  (end_of_file),
    .start_of_file(start_of_file),
    .job_valid    (job_valid),
    .job          (job)
  );

  vpcp_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_valid),
    .wdata    (job),
    .rd       (q_rd),
    .rdata    (q_data),
    .full     (full),
    .not_empty(q_not_empty)
  );

  vpcp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_data       (q_data),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .record_kind  (record_kind),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .text_rotation(text_rotation),
    .text_align   (text_align),
    .char_code    (char_code),
    .needs_escape (needs_escape),
    .last_of_run  (last_of_run)
  );

endmodule

### rtl/core/vpcp_checker.sv
// Port-level checks for the vector picture command parser, bound to the top.
// Depends on vpcp_pkg for record kinds.
module vpcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  record_kind,
  input logic [15:0] coord_x,
  input logic [15:0] coord_y,
  input logic        last_of_run
);

  // A waiting record holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(record_kind) && $stable(coord_x) &&
                          $stable(coord_y) && $stable(last_of_run)))
    else $error("waiting record changed before pop");

  // An error is always followed by a page end from the same byte.
  a_err_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_kind == vpcp_pkg::K_ERROR) |-> !last_of_run)
    else $error("error record marked last");

  // Page end closes the run of its byte.
  a_page_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_kind == vpcp_pkg::K_PAGE) |-> last_of_run)
    else $error("page end not marked last");

  // Text begin is always followed by its first character.
  a_tbegin_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_kind == vpcp_pkg::K_TBEGIN) |-> !last_of_run)
    else $error("text begin marked last");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

endmodule

bind vector_picture_command_parser vpcp_checker u_vpcp_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .record_kind(record_kind),
  .coord_x    (coord_x),
  .coord_y    (coord_y),
  .last_of_run(last_of_run)
);

### sim/tb_vector_picture_command_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for vector_picture_command_parser: byte requests in, drawing records
// out, compared field by field against a predictor kept in this file. Needs rtl vpcp_pkg.

module tb_vector_picture_command_parser;

  localparam int HDR_LEN     = 17;
  localparam int TEXT_MAX    = 254;
  localparam int HOLD_CYCLES = 200;

  localparam logic [7:0] OP_MOVE      = 8'hA0;
  localparam logic [7:0] OP_DRAW      = 8'hA2;
  localparam logic [7:0] OP_POLY      = 8'h30;
  localparam logic [7:0] OP_POLY_FILL = 8'hD0;
  localparam logic [7:0] OP_FONT      = 8'hAC;
  localparam logic [7:0] OP_FONT_SEL  = 8'hA7;
  localparam logic [7:0] OP_TEXT      = 8'hA8;
  localparam logic [7:0] OP_END       = 8'h60;
  localparam logic [7:0] OP_COLOR     = 8'hB0;
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_BSLASH    = 8'h5C;

  typedef enum logic [10:0] {
    ST_HEADER      = 11'b000_0000_0001,
    ST_OPCODE      = 11'b000_0000_0010,
    ST_MOVE        = 11'b000_0000_0100,
    ST_DRAW        = 11'b000_0000_1000,
    ST_POLY_COUNT  = 11'b000_0001_0000,
    ST_POLY_START  = 11'b000_0010_0000,
    ST_POLY_VERTEX = 11'b000_0100_0000,
    ST_FONT        = 11'b000_1000_0000,
    ST_SKIP        = 11'b001_0000_0000,
    ST_ALIGN       = 11'b010_0000_0000,
    ST_TEXT        = 11'b100_0000_0000
  } parse_state_t;

  typedef struct packed {
    vpcp_pkg::kind_t kind;
    logic [15:0]     x;
    logic [15:0]     y;
    logic [1:0]      rot;
    logic [2:0]      align;
    logic [7:0]      chr;
    logic            esc;
    logic            last;
  } record_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_file = 1'b0;
  logic        start_of_file = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  record_kind;
  logic [15:0] coord_x;
  logic [15:0] coord_y;
  logic [1:0]  text_rotation;
  logic [2:0]  text_align;
  logic [7:0]  char_code;
  logic        needs_escape;
  logic        last_of_run;

  // Predictor state.
  logic [4:0]   hdr_left;
  parse_state_t phase;
  logic [2:0]   opnd_idx;
  logic [7:0]   hi_byte;
  logic [15:0]  move_x, move_y, line_x, font_w, font_h;
  logic [7:0]   verts_left, text_len;
  logic [1:0]   txt_rot;
  logic [2:0]   txt_align;
  logic         stroke_pending, move_pending, font_pending, page_done;

  record_t step_records[$];
  record_t expected_records[$];

  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;
  int mismatch_count = 0;
  int records_checked = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int stall_cycles = 0;

  vector_picture_command_parser #(
    .HEADER_BYTES(HDR_LEN),
    .TEXT_LIMIT  (TEXT_MAX)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .end_of_file  (end_of_file),
    .start_of_file(start_of_file),
    .empty        (empty),
    .pop          (pop),
    .record_kind  (record_kind),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .text_rotation(text_rotation),
    .text_align   (text_align),
    .char_code    (char_code),
    .needs_escape (needs_escape),
    .last_of_run  (last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_record(vpcp_pkg::kind_t kind, logic [15:0] x, logic [15:0] y,
                                     logic [1:0] rot, logic [2:0] align, logic [7:0] chr,
                                     logic esc);
    record_t r;
    r.kind  = kind;
    r.x     = x;
    r.y     = y;
    r.rot   = rot;
    r.align = align;
    r.chr   = chr;
    r.esc   = esc;
    r.last  = 1'b0;
    step_records.push_back(r);
  endfunction

  function automatic void close_stroke();
    if (stroke_pending) begin
      add_record(vpcp_pkg::K_STROKE, 16'd0, 16'd0, 2'd0, 3'd0, 8'd0, 1'b0);
      stroke_pending = 1'b0;
    end
  endfunction

  function automatic void place_move();
    if (move_pending) begin
      add_record(vpcp_pkg::K_MOVETO, move_x, move_y, 2'd0, 3'd0, 8'd0, 1'b0);
      move_pending = 1'b0;
    end
  endfunction

  function automatic void end_page();
    close_stroke();
    add_record(vpcp_pkg::K_PAGE, 16'd0, 16'd0, 2'd0, 3'd0, 8'd0, 1'b0);
    page_done = 1'b1;
  endfunction

  function automatic void clear_parser();
    hdr_left       = 5'(HDR_LEN);
    phase          = (HDR_LEN > 0) ? ST_HEADER : ST_OPCODE;
    opnd_idx       = '0;
    hi_byte        = '0;
    move_x         = '0;
    move_y         = '0;
    line_x         = '0;
    font_w         = '0;
    font_h         = '0;
    verts_left     = '0;
    text_len       = '0;
    txt_rot        = '0;
    txt_align      = '0;
    stroke_pending = 1'b0;
    move_pending   = 1'b0;
    font_pending   = 1'b0;
    page_done      = 1'b0;
  endfunction

  function automatic void decode_opcode(logic [7:0] b);
    opnd_idx = '0;
    if (b[7:4] == OP_COLOR[7:4]) return;
    case (b)
      OP_MOVE:               phase = ST_MOVE;
      OP_DRAW:               phase = ST_DRAW;
      OP_POLY, OP_POLY_FILL: phase = ST_POLY_COUNT;
      OP_FONT:               phase = ST_FONT;
      OP_FONT_SEL:           phase = ST_SKIP;
      OP_TEXT:               phase = ST_ALIGN;
      default: begin
        if (b[7:4] != OP_END[7:4]) begin
          add_record(vpcp_pkg::K_ERROR, 16'd0, 16'd0, 2'd0, 3'd0, b, 1'b0);
        end
        end_page();
      end
    endcase
  endfunction

  function automatic void text_byte(logic [7:0] b);
    logic esc;
    if (b == CH_NUL) begin
      if (text_len != 0) add_record(vpcp_pkg::K_TEND, 16'd0, 16'd0, 2'd0, 3'd0, 8'd0, 1'b0);
      text_len = '0;
      phase    = ST_OPCODE;
      return;
    end
    if (text_len >= TEXT_MAX) return;
    esc = (b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_BSLASH);
    // The first kept character announces the string with everything held back.
    if (text_len == 0) begin
      close_stroke();
      if (font_pending) begin
        add_record(vpcp_pkg::K_FONT, font_w, font_h, 2'd0, 3'd0, 8'd0, 1'b0);
        font_pending = 1'b0;
      end
      place_move();
      add_record(vpcp_pkg::K_TBEGIN, 16'd0, 16'd0, txt_rot, txt_align, 8'd0, 1'b0);
    end
    add_record(vpcp_pkg::K_TCHAR, 16'd0, 16'd0, 2'd0, 3'd0, b, esc);
    text_len = text_len + 8'd1 + {7'd0, esc};
  endfunction

  function automatic void operand_byte(logic [7:0] b);
    logic [1:0]  idx;
    logic [15:0] word;
    idx  = opnd_idx[1:0];
    word = {hi_byte, b};
    if (!idx[0]) begin
      hi_byte  = b;
      opnd_idx = {1'b0, idx + 2'd1};
      return;
    end
    if (idx == 2'd1) begin
      if (phase == ST_MOVE || phase == ST_POLY_START) move_x = word;
      else if (phase == ST_FONT) font_w = word;
      else line_x = word;
      opnd_idx = 3'd2;
      return;
    end
    opnd_idx = '0;
    case (phase)
      ST_MOVE: begin
        move_y = word;
        close_stroke();
        move_pending = 1'b1;
        phase = ST_OPCODE;
      end
      ST_DRAW: begin
        place_move();
        add_record(vpcp_pkg::K_LINETO, line_x, word, 2'd0, 3'd0, 8'd0, 1'b0);
        stroke_pending = 1'b1;
        phase = ST_OPCODE;
      end
      ST_FONT: begin
        font_h = word;
        font_pending = 1'b1;
        phase = ST_OPCODE;
      end
      ST_POLY_START: begin
        move_y = word;
        add_record(vpcp_pkg::K_MOVETO, move_x, move_y, 2'd0, 3'd0, 8'd0, 1'b0);
        phase = ST_POLY_VERTEX;
      end
      default: begin
        add_record(vpcp_pkg::K_LINETO, line_x, word, 2'd0, 3'd0, 8'd0, 1'b0);
        if (verts_left != 0) verts_left = verts_left - 8'd1;
      end
    endcase
    if (phase == ST_POLY_VERTEX && verts_left == 0) begin
      add_record(vpcp_pkg::K_CLOSE, 16'd0, 16'd0, 2'd0, 3'd0, 8'd0, 1'b0);
      phase = ST_OPCODE;
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    case (phase)
      ST_HEADER: begin
        if (hdr_left != 0) hdr_left = hdr_left - 5'd1;
        if (hdr_left == 0) phase = ST_OPCODE;
      end
      ST_OPCODE: decode_opcode(b);
      ST_SKIP:   phase = ST_OPCODE;
      ST_ALIGN: begin
        txt_rot   = b[5:4];
        txt_align = b[2:0];
        text_len  = '0;
        phase     = ST_TEXT;
      end
      ST_TEXT: text_byte(b);
      ST_POLY_COUNT: begin
        verts_left = b;
        opnd_idx   = '0;
        phase      = ST_POLY_START;
      end
      default: operand_byte(b);
    endcase
  endfunction

  function automatic void predict_records(logic [7:0] b, logic eof, logic sof);
    record_t r;
    step_records.delete();
    if (sof) clear_parser();
    if (!page_done) begin
      if (phase != ST_HEADER && !eof) live_bytes++;
      if (eof) begin
        if (phase == ST_TEXT && text_len != 0) begin
          add_record(vpcp_pkg::K_TEND, 16'd0, 16'd0, 2'd0, 3'd0, 8'd0, 1'b0);
        end
        text_len = '0;
        end_page();
      end else begin
        parse_byte(b);
      end
    end
    foreach (step_records[i]) begin
      r = step_records[i];
      r.last = (i == step_records.size() - 1);
      expected_records.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: record %0d: %s is %0h, expected %0h", $time, records_checked, what, got,
             want);
    mismatch_count++;
  endtask

  task automatic compare_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : check_records
    record_t want;
    if (!rst && push && full) stall_cycles++;
    if (!rst && pop && !empty) begin
      records_checked++;
      if (expected_records.size() == 0) begin
        report_mismatch("unexpected record_kind", 16'(record_kind), 16'd0);
      end else begin
        want = expected_records.pop_front();
        compare_field("record_kind", 16'(record_kind), 16'(want.kind));
        compare_field("coord_x", coord_x, want.x);
        compare_field("coord_y", coord_y, want.y);
        compare_field("text_rotation", 16'(text_rotation), 16'(want.rot));
        compare_field("text_align", 16'(text_align), 16'(want.align));
        compare_field("char_code", 16'(char_code), 16'(want.chr));
        compare_field("needs_escape", 16'(needs_escape), 16'(want.esc));
        compare_field("last_of_run", 16'(last_of_run), 16'(want.last));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : drain_records
    int n;
    wait (!rst);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_request = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_request(logic [7:0] b, logic eof, logic sof);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push          <= 1'b1;
    data_byte     <= b;
    end_of_file   <= eof;
    start_of_file <= sof;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_records(b, eof, sof);
    bytes_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(b, 1'b0, 1'b0);
  endtask

  task automatic send_word(logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  task automatic send_eof();
    send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  task automatic send_header();
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    repeat (HDR_LEN - 1) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0:       return CH_LPAREN;
        1:       return CH_RPAREN;
        default: return CH_BSLASH;
      endcase
    end
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_random_file();
    int cmds, n, len;
    send_header();
    cmds = $urandom_range(3, 10);
    repeat (cmds) begin
      case ($urandom_range(0, 9))
        0: begin
          send_byte(OP_MOVE);
          send_word(pick_coord());
          send_word(pick_coord());
        end
        1, 2: begin
          send_byte(OP_DRAW);
          send_word(pick_coord());
          send_word(pick_coord());
        end
        3: begin
          send_byte($urandom_range(0, 1) ? OP_POLY : OP_POLY_FILL);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
          send_byte(8'(n));
          repeat (n + 1) begin
            send_word(pick_coord());
            send_word(pick_coord());
          end
        end
        4: begin
          send_byte(OP_FONT);
          send_word(pick_coord());
          send_word(pick_coord());
        end
        5: begin
          send_byte(OP_FONT_SEL);
          send_byte(8'($urandom_range(0, 255)));
        end
        6: send_byte(OP_COLOR | 8'($urandom_range(0, 15)));
        7, 8: begin
          send_byte(OP_TEXT);
          send_byte(8'($urandom_range(0, 255)));
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 200) : $urandom_range(0, 6);
          repeat (len) send_byte(pick_char());
          send_byte(CH_NUL);
        end
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    case ($urandom_range(0, 5))
      0: send_eof();
      1: begin
        send_byte(OP_DRAW);
        send_byte(8'($urandom_range(0, 255)));
        send_eof();
      end
      2: begin
        send_byte(OP_TEXT);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(pick_char());
        send_eof();
      end
      3: ;
      default: send_byte(OP_END | 8'($urandom_range(0, 15)));
    endcase
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_header_and_flags();
    // Both flags together clear the parser and finish with a bare page end.
    send_request(8'hFF, 1'b1, 1'b1);
    send_eof();
    send_byte(8'h00);
    send_request(8'h00, 1'b0, 1'b1);
    repeat (5) send_byte(8'hFF);
    send_eof();
  endtask

  task automatic test_draw_path();
    send_header();
    send_byte(OP_MOVE);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_byte(OP_DRAW);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_byte(OP_DRAW);
    send_word(16'h1234);
    send_word(16'h5678);
    send_byte(OP_COLOR | 8'h0F);
    send_byte(OP_FONT_SEL);
    send_byte(OP_DRAW);
    send_byte(OP_FONT);
    send_word(16'h0010);
    send_word(16'h0020);
    send_byte(OP_MOVE);
    send_word(16'hABCD);
    send_word(16'h0001);
    send_byte(OP_DRAW);
    send_word(16'h0002);
    send_word(16'h0003);
    send_byte(OP_END | 8'h0F);
  endtask

  task automatic test_polygon();
    send_header();
    send_byte(OP_POLY);
    send_byte(8'd0);
    send_word(16'h0102);
    send_word(16'h0304);
    send_byte(OP_POLY_FILL);
    send_byte(8'd2);
    repeat (3) begin
      send_word(pick_coord());
      send_word(pick_coord());
    end
    send_byte(OP_DRAW);
    send_word(16'h0005);
    send_word(16'h0006);
    send_byte(OP_END);
  endtask

  task automatic test_text();
    send_header();
    send_byte(OP_DRAW);
    send_word(16'h0100);
    send_word(16'h0200);
    send_byte(OP_FONT);
    send_word(16'h000C);
    send_word(16'h0018);
    send_byte(OP_TEXT);
    send_byte(8'h35);
    send_byte(8'h61);
    send_byte(CH_LPAREN);
    send_byte(CH_BSLASH);
    send_byte(CH_RPAREN);
    send_byte(CH_NUL);
    // An empty string produces nothing at all.
    send_byte(OP_TEXT);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_byte(OP_MOVE);
    send_word(16'h0040);
    send_word(16'h0080);
    send_byte(OP_TEXT);
    send_byte(8'h12);
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_byte(OP_TEXT);
    send_byte(8'h07);
    send_byte(8'h68);
    send_eof();
  endtask

  task automatic test_text_limit();
    // Escaped length reaches 253, one more escaped character still fits, then drops start.
    send_header();
    send_byte(OP_TEXT);
    send_byte(8'h00);
    repeat (126) send_byte(CH_BSLASH);
    send_byte(8'h61);
    send_byte(CH_RPAREN);
    send_byte(8'h62);
    send_byte(CH_NUL);
    send_byte(OP_END);
  endtask

  task automatic test_unknown_opcode();
    send_header();
    send_byte(OP_DRAW);
    send_word(16'h0011);
    send_word(16'h0022);
    send_byte(8'h00);
    // Everything after the error is ignored until the next file.
    send_byte(OP_DRAW);
    send_word(16'h0033);
    send_word(16'h0044);
    send_eof();
    send_header();
    send_byte(8'hFF);
    send_byte(OP_END);
  endtask

  task automatic test_end_of_input();
    send_header();
    send_byte(OP_DRAW);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_byte(OP_MOVE);
    send_byte(8'h12);
    send_eof();
    // A new file starting in the middle of an operand throws the old one away.
    send_header();
    send_byte(OP_DRAW);
    send_byte(8'h55);
    send_request(8'hA5, 1'b0, 1'b1);
    repeat (HDR_LEN - 1) send_byte(8'h00);
    send_byte(OP_END);
  endtask

  task automatic test_back_pressure();
    gaps_on = 1'b0;
    send_header();
    hold_request = 1'b1;
    send_byte(OP_TEXT);
    send_byte(8'h21);
    repeat (40) send_byte(pick_char());
    send_byte(CH_NUL);
    send_byte(OP_END);
    while (hold_request) @(posedge clk);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_files();
    int first;
    first = live_bytes;
    while (live_bytes - first < 120) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      send_random_file();
    end
  endtask

  task automatic test_streaming();
    gaps_on = 1'b0;
    repeat (2) send_random_file();
  endtask

  initial begin : run_tests
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_header_and_flags();
    test_draw_path();
    test_polygon();
    test_text();
    test_text_limit();
    test_unknown_opcode();
    test_end_of_input();
    test_back_pressure();
    test_random_files();
    test_streaming();
    push <= 1'b0;
    for (n = 0; n < 5000 && expected_records.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_records.size() != 0) begin
      report_mismatch("records never delivered, count", 16'(expected_records.size()), 16'd0);
    end
    $display("Sent %0d byte requests (%0d parsed past the header), checked %0d records.",
             bytes_sent, live_bytes, records_checked);
    $display("Input stalled on a full queue for %0d cycles.", stall_cycles);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
